FILE: rtl/pnbe_pkg.sv
package pnbe_pkg;

    localparam int MaxDigitOctetsDef = 32;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 7;
    localparam int QueueDepth = 3;

    localparam logic [CfgIdxW-1:0] REG_PARTY_KIND      = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_ADDRESS_NATURE  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_INDICATOR_BIT   = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_NUMBERING_PLAN  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_PRESENTATION    = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_SCREENING_MODE  = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_BUFFER_CAPACITY = 3'd6;

    localparam logic [5:0] CapacityReset = 6'd34;
    localparam logic [5:0] HeaderOctets  = 6'd2;

    localparam logic [3:0] NibStar = 4'h0b;
    localparam logic [3:0] NibHash = 4'h0c;
    localparam logic [3:0] NibHexA = 4'h0a;

    typedef struct packed {
        logic [7:0] octet_value;
        logic [5:0] octet_pos;
        logic [5:0] total_length;
        logic       failed;
        logic       final_result;
    } t_res;

    typedef struct packed {
        logic       load;
        logic [1:0] load_cnt;
        logic       pop;
    } t_q_ctl;

    // {valid, nibble}
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if (c == 8'h2a) begin
            r = {1'b1, NibStar};
        end else if (c == 8'h23) begin
            r = {1'b1, NibHash};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            // 'a'/'A' low three bits are 1..6
            r = {1'b1, NibHexA + 4'(c[2:0] - 3'd1)};
        end
        return r;
    endfunction

endpackage

FILE: rtl/pnbe_in_if.sv
interface pnbe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       char_present;
    logic       last_char;

    modport source (output valid, output char_code, output char_present,
                    output last_char, input ready);
    modport sink (input valid, input char_code, input char_present,
                  input last_char, output ready);
endinterface

FILE: rtl/pnbe_out_if.sv
interface pnbe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] octet_value;
    logic [5:0] octet_pos;
    logic [5:0] total_length;
    logic       failed;
    logic       final_result;

    modport source (output valid, output octet_value, output octet_pos,
                    output total_length, output failed, output final_result,
                    input ready);
    modport sink (input valid, input octet_value, input octet_pos,
                  input total_length, input failed, input final_result,
                  output ready);
endinterface

FILE: rtl/pnbe_resq.sv
module pnbe_resq
    import pnbe_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_q_ctl i_ctl,
    input  t_res   i_data [QueueDepth],
    output t_res   o_head,
    output logic [1:0] o_left
);

    t_res       r_slot [QueueDepth];
    logic [1:0] r_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
        end else if (i_ctl.load) begin
            r_left <= i_ctl.load_cnt;
        end else if (i_ctl.pop) begin
            r_left <= r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_slot <= i_data;
        end else if (i_ctl.pop) begin
            for (int i = 0; i < QueueDepth - 1; i++) begin
                r_slot[i] <= r_slot[i+1];
            end
        end
    end

    assign o_head = r_slot[0];
    assign o_left = r_left;

endmodule

FILE: rtl/party_number_bcd_encoder.sv
// The input register holds an accepted character; its result beats go to the result
// queue, which drives the output. Throughput: one character per cycle while the
// output takes each result beat; a final character yields one to three result beats,
// one per cycle while the output is ready, and input stalls until the last of them
// is being taken. Reset (synchronous, active low): packing state and queue cleared,
// registers to their defaults, buffer capacity 34.
module party_number_bcd_encoder
    import pnbe_pkg::*;
#(
    parameter int MAX_DIGIT_OCTETS = MaxDigitOctetsDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    pnbe_in_if.sink             i_char,
    pnbe_out_if.source          o_octet
);

    // configuration
    logic       r_party_kind;
    logic [6:0] r_address_nature;
    logic       r_indicator_bit;
    logic [2:0] r_numbering_plan;
    logic [1:0] r_presentation;
    logic [1:0] r_screening_mode;
    logic [5:0] r_buffer_capacity;

    // packing state
    logic [3:0] r_pend, n_pend;
    logic       r_odd, n_odd;
    logic [5:0] r_done, n_done;
    logic       r_err, n_err;

    // input register
    logic       r_in_v;
    logic [7:0] r_in_code;
    logic       r_in_present;
    logic       r_in_last;

    t_res       res [QueueDepth];
    logic [1:0] res_cnt;
    t_q_ctl     q_ctl;
    t_res       q_head;
    logic [1:0] q_left;
    logic       consume;
    logic       out_pop;
    logic [4:0] nib;
    logic [5:0] room;
    logic [5:0] cap_m2;
    logic       cap_low;
    t_res       first;
    logic       first_v;
    logic [7:0] h1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_party_kind      <= 1'b0;
            r_address_nature  <= 7'd0;
            r_indicator_bit   <= 1'b0;
            r_numbering_plan  <= 3'd0;
            r_presentation    <= 2'd0;
            r_screening_mode  <= 2'd0;
            r_buffer_capacity <= CapacityReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PARTY_KIND:      r_party_kind      <= i_cfg_data[0];
                REG_ADDRESS_NATURE:  r_address_nature  <= i_cfg_data[6:0];
                REG_INDICATOR_BIT:   r_indicator_bit   <= i_cfg_data[0];
                REG_NUMBERING_PLAN:  r_numbering_plan  <= i_cfg_data[2:0];
                REG_PRESENTATION:    r_presentation    <= i_cfg_data[1:0];
                REG_SCREENING_MODE:  r_screening_mode  <= i_cfg_data[1:0];
                REG_BUFFER_CAPACITY: r_buffer_capacity <= {1'b0, i_cfg_data[4:0]}
                                                          | {i_cfg_data[5], 5'd0};
                default: ;
            endcase
        end
    end

    assign out_pop = o_octet.valid && o_octet.ready;
    assign consume = r_in_v && (q_left == 2'd0 || (q_left == 2'd1 && o_octet.ready));
    assign i_char.ready = !r_in_v || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (i_char.valid && i_char.ready) begin
            r_in_v <= 1'b1;
        end else if (consume) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_in_code    <= i_char.char_code;
            r_in_present <= i_char.char_present;
            r_in_last    <= i_char.last_char;
        end
    end

    assign cap_low = r_buffer_capacity < HeaderOctets;
    assign cap_m2  = r_buffer_capacity - HeaderOctets;
    assign room    = cap_low ? 6'd0
                   : (cap_m2 > 6'(MAX_DIGIT_OCTETS) ? 6'(MAX_DIGIT_OCTETS) : cap_m2);
    assign nib     = nibble_of(r_in_code);

    always_comb begin
        n_pend  = r_pend;
        n_odd   = r_odd;
        n_done  = r_done;
        n_err   = r_err;
        first   = '0;
        first_v = 1'b0;
        h1      = '0;
        res_cnt = 2'd0;
        for (int i = 0; i < QueueDepth; i++) begin
            res[i] = '0;
        end

        if (r_in_present && !r_err) begin
            if (!nib[4]) begin
                n_err = 1'b1;
            end else if (!r_odd) begin
                if (r_done >= room) begin
                    n_err = 1'b1;
                end else begin
                    n_pend = nib[3:0];
                    n_odd  = 1'b1;
                end
            end else begin
                first_v = 1'b1;
                first.octet_value = {nib[3:0], r_pend};
                first.octet_pos   = HeaderOctets + r_done;
                n_done = r_done + 6'd1;
                n_pend = 4'd0;
                n_odd  = 1'b0;
            end
        end

        if (r_in_last) begin
            if (n_err || cap_low) begin
                res[0].failed       = 1'b1;
                res[0].final_result = 1'b1;
                res_cnt = 2'd1;
                if (first_v) begin
                    res[0] = first;
                    res[1].failed       = 1'b1;
                    res[1].final_result = 1'b1;
                    res_cnt = 2'd2;
                end
            end else begin
                // odd digit count: half octet with zero filler goes out first
                if (n_odd) begin
                    first_v = 1'b1;
                    first.octet_value = {4'd0, n_pend};
                    first.octet_pos   = HeaderOctets + n_done;
                    n_done = n_done + 6'd1;
                end
                h1 = {r_indicator_bit, r_numbering_plan, 4'd0};
                if (r_party_kind) begin
                    h1[3:0] = {r_presentation, r_screening_mode};
                end
                if (first_v) begin
                    res[0] = first;
                    res[1].octet_value  = {n_odd, r_address_nature};
                    res[2].octet_value  = h1;
                    res[2].octet_pos    = 6'd1;
                    res[2].total_length = HeaderOctets + n_done;
                    res[2].final_result = 1'b1;
                    res_cnt = 2'd3;
                end else begin
                    res[0].octet_value  = {n_odd, r_address_nature};
                    res[1].octet_value  = h1;
                    res[1].octet_pos    = 6'd1;
                    res[1].total_length = HeaderOctets + n_done;
                    res[1].final_result = 1'b1;
                    res_cnt = 2'd2;
                end
            end
            n_pend = 4'd0;
            n_odd  = 1'b0;
            n_done = 6'd0;
            n_err  = 1'b0;
        end else if (first_v) begin
            res[0]  = first;
            res_cnt = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 4'd0;
            r_odd  <= 1'b0;
            r_done <= 6'd0;
            r_err  <= 1'b0;
        end else if (consume) begin
            r_pend <= n_pend;
            r_odd  <= n_odd;
            r_done <= n_done;
            r_err  <= n_err;
        end
    end

    assign q_ctl.load     = consume;
    assign q_ctl.load_cnt = res_cnt;
    assign q_ctl.pop      = out_pop;

    pnbe_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (q_ctl),
        .i_data  (res),
        .o_head  (q_head),
        .o_left  (q_left)
    );

    assign o_octet.valid        = q_left != 2'd0;
    assign o_octet.octet_value  = q_head.octet_value;
    assign o_octet.octet_pos    = q_head.octet_pos;
    assign o_octet.total_length = q_head.total_length;
    assign o_octet.failed       = q_head.failed;
    assign o_octet.final_result = q_head.final_result;

    a_fail_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_octet.valid && o_octet.failed |->
            o_octet.final_result && o_octet.octet_value == 8'd0)
        else $error("error beat not final or not zero");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && r_in_last |=> !r_odd && !r_err && r_done == 6'd0)
        else $error("packing state not cleared after last character");

    a_done_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done <= 6'(MAX_DIGIT_OCTETS))
        else $error("digit octet count beyond limit");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume |-> q_left == 2'd0 || out_pop)
        else $error("result queue loaded while holding beats");

endmodule
